FILE: rtl/core/assert_macros.svh
// Assertion helpers for the RTL; every use samples on clk_i and is gated by rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define LCR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("implication failed");

// Next-cycle implication.
`define LCR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

FILE: rtl/core/lcr_pkg.sv
package lcr_pkg;

  localparam int unsigned CFG_ADDR_W = 5;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned COST_W     = 24;
  localparam int unsigned WEIGHT_W   = 16;

  localparam logic [7:0] COST_UNKNOWN = 8'd255;

  typedef enum logic [2:0] {
    ST_SCORED     = 3'd0,
    ST_COLLISION  = 3'd1,
    ST_OFF_REJECT = 3'd2,
    ST_OFF_ACCEPT = 3'd3,
    ST_NO_MAP     = 3'd4,
    ST_TOO_LONG   = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    REG_USE_MAX     = 3'd0,
    REG_REJECT_COLL = 3'd1,
    REG_REJECT_OFF  = 3'd2,
    REG_COST_CAP    = 3'd3,
    REG_STRIDE      = 3'd4,
    REG_WEIGHT      = 3'd5,
    REG_MAP_READY   = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic                use_max;
    logic                reject_coll;
    logic                reject_off;
    logic [7:0]          cost_cap;
    logic [7:0]          stride;
    logic [WEIGHT_W-1:0] weight;
    logic                map_ready;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    use_max:     1'b1,
    reject_coll: 1'b1,
    reject_off:  1'b1,
    cost_cap:    8'd253,
    stride:      8'd2,
    weight:      16'd256,
    map_ready:   1'b0
  };

  // A zero threshold behaves as one.
  function automatic logic [7:0] eff_cost_cap(input logic [7:0] mc);
    return (mc == 8'd0) ? 8'd1 : mc;
  endfunction

endpackage

FILE: rtl/core/lcr_if.sv
interface lcr_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] cell_cost;
  logic       last_cell;

  modport source (output valid, req_type, cell_cost, last_cell, input ready);
  modport sink   (input valid, req_type, cell_cost, last_cell, output ready);
endinterface

interface lcr_out_if;
  logic                              valid;
  logic                              ready;
  logic                              edge_ok;
  lcr_pkg::status_e                  status;
  logic [lcr_pkg::COST_W-1:0]        edge_cost;

  modport source (output valid, edge_ok, status, edge_cost, input ready);
  modport sink   (input valid, edge_ok, status, edge_cost, output ready);
endinterface

FILE: rtl/core/lcr_cfg_regs.sv
module lcr_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lcr_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [lcr_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [lcr_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready,
  output lcr_pkg::cfg_t                   cfg_o
);
  import lcr_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_e'(paddr[CFG_ADDR_W-1:2]);
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_USE_MAX:     cfg_d.use_max     = pwdata[0];
        REG_REJECT_COLL: cfg_d.reject_coll = pwdata[0];
        REG_REJECT_OFF:  cfg_d.reject_off  = pwdata[0];
        REG_COST_CAP:    cfg_d.cost_cap    = pwdata[7:0];
        REG_STRIDE:      cfg_d.stride      = pwdata[7:0];
        REG_WEIGHT:      cfg_d.weight      = pwdata[WEIGHT_W-1:0];
        REG_MAP_READY:   cfg_d.map_ready   = pwdata[0];
        default:         cfg_d             = cfg_q;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      REG_USE_MAX:     prdata[0]            = cfg_q.use_max;
      REG_REJECT_COLL: prdata[0]            = cfg_q.reject_coll;
      REG_REJECT_OFF:  prdata[0]            = cfg_q.reject_off;
      REG_COST_CAP:    prdata[7:0]          = cfg_q.cost_cap;
      REG_STRIDE:      prdata[7:0]          = cfg_q.stride;
      REG_WEIGHT:      prdata[WEIGHT_W-1:0] = cfg_q.weight;
      REG_MAP_READY:   prdata[0]            = cfg_q.map_ready;
      default:         prdata               = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

FILE: rtl/core/lcr_front.sv
module lcr_front #(
  parameter int unsigned MAX_SAMPLES = 4096
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  lcr_pkg::cfg_t                             cfg_i,
  input  logic                                      in_valid_i,
  output logic                                      in_ready_o,
  input  logic                                      req_type_i,
  input  logic [7:0]                                cell_cost_i,
  input  logic                                      last_cell_i,
  input  logic                                      q_full_i,
  output logic                                      push_o,
  output lcr_pkg::status_e                          job_status_o,
  output logic [7:0]                                job_largest_o,
  output logic [$clog2(MAX_SAMPLES*255+1)-1:0]      job_sum_o,
  output logic [$clog2(MAX_SAMPLES+1)-1:0]          job_count_o
);
  import lcr_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned SUM_W = $clog2(MAX_SAMPLES * 255 + 1);

  logic [SUM_W-1:0] sum_q, sum_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [7:0]       largest_q, largest_d;
  logic [7:0]       pos_q, pos_d;
  logic             coll_q, coll_d;
  logic             ov_q, ov_d;

  logic [7:0] mc, stride;
  logic [8:0] pos_inc;
  logic       fire, end_edge, sample, full, hit, take;

  assign in_ready_o = ~q_full_i;
  assign fire       = in_valid_i & in_ready_o;
  assign end_edge   = fire & (req_type_i | last_cell_i);
  assign push_o     = end_edge;

  assign mc     = eff_cost_cap(cfg_i.cost_cap);
  assign stride = (cfg_i.stride == 8'd0) ? 8'd1 : cfg_i.stride;

  assign sample = (pos_q == 8'd0);
  assign full   = (count_q == CNT_W'(MAX_SAMPLES));
  assign hit    = sample & (cell_cost_i >= mc) & (mc != COST_UNKNOWN) & cfg_i.reject_coll;
  assign take   = sample & ~full;

  always_comb begin
    sum_d     = sum_q;
    count_d   = count_q;
    largest_d = largest_q;
    if (take) begin
      sum_d   = sum_q + SUM_W'(cell_cost_i);
      count_d = count_q + CNT_W'(1);
      if (cell_cost_i != COST_UNKNOWN && cell_cost_i > largest_q) begin
        largest_d = cell_cost_i;
      end
    end
    coll_d  = coll_q | hit;
    ov_d    = ov_q | (sample & full);
    pos_inc = {1'b0, pos_q} + 9'd1;
    pos_d   = (pos_inc >= {1'b0, stride}) ? 8'd0 : pos_inc[7:0];
  end

  // Classify the edge as it ends; only scored edges need the back end's divider.
  always_comb begin
    if (!cfg_i.map_ready) begin
      job_status_o = ST_NO_MAP;
    end else if (req_type_i) begin
      job_status_o = cfg_i.reject_off ? ST_OFF_REJECT : ST_OFF_ACCEPT;
    end else if (coll_d) begin
      job_status_o = ST_COLLISION;
    end else if (ov_d) begin
      job_status_o = ST_TOO_LONG;
    end else begin
      job_status_o = ST_SCORED;
    end
  end

  assign job_sum_o     = sum_d;
  assign job_count_o   = count_d;
  assign job_largest_o = largest_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q     <= '0;
      count_q   <= '0;
      largest_q <= '0;
      pos_q     <= '0;
      coll_q    <= 1'b0;
      ov_q      <= 1'b0;
    end else if (fire) begin
      if (end_edge) begin
        sum_q     <= '0;
        count_q   <= '0;
        largest_q <= '0;
        pos_q     <= '0;
        coll_q    <= 1'b0;
        ov_q      <= 1'b0;
      end else begin
        sum_q     <= sum_d;
        count_q   <= count_d;
        largest_q <= largest_d;
        pos_q     <= pos_d;
        coll_q    <= coll_d;
        ov_q      <= ov_d;
      end
    end
  end

endmodule

FILE: rtl/core/lcr_queue.sv
module lcr_queue #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] data_i,
  input  logic              pop_i,
  output logic              valid_o,
  output logic              full_o,
  output logic [DATA_W-1:0] data_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]  count_q;
  logic              do_push, do_pop;

  assign valid_o = (count_q != '0);
  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= ptr_next(wr_ptr_q);
      if (do_pop)  rd_ptr_q <= ptr_next(rd_ptr_q);
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + CNT_W'(1);
        2'b01:   count_q <= count_q - CNT_W'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

FILE: rtl/core/lcr_back.sv
module lcr_back #(
  parameter int unsigned MAX_SAMPLES = 4096
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  lcr_pkg::cfg_t                             cfg_i,
  input  logic                                      job_valid_i,
  input  lcr_pkg::status_e                          job_status_i,
  input  logic [7:0]                                job_largest_i,
  input  logic [$clog2(MAX_SAMPLES*255+1)-1:0]      job_sum_i,
  input  logic [$clog2(MAX_SAMPLES+1)-1:0]          job_count_i,
  output logic                                      pop_o,
  output logic                                      out_valid_o,
  input  logic                                      out_ready_i,
  output logic                                      out_ok_o,
  output lcr_pkg::status_e                          out_status_o,
  output logic [lcr_pkg::COST_W-1:0]                out_cost_o
);
  import lcr_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned SUM_W = $clog2(MAX_SAMPLES * 255 + 1);
  localparam int unsigned NUM_W = WEIGHT_W + SUM_W;
  localparam int unsigned DEN_W = CNT_W + 8;
  localparam int unsigned IT_W  = $clog2(NUM_W + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_OUT
  } state_e;

  state_e              state_q;
  logic [NUM_W-1:0]    quot_q;
  logic [DEN_W-1:0]    den_q;
  logic [DEN_W-1:0]    rem_q;
  logic [IT_W-1:0]     it_q;
  logic                out_valid_q;
  logic                out_ok_q;
  status_e             out_status_q;
  logic [COST_W-1:0]   out_cost_q;

  logic [7:0]          mc;
  logic [NUM_W-1:0]    num_mul;
  logic [DEN_W-1:0]    den_mul;
  logic [DEN_W:0]      rem_sh, diff;
  logic                ge, out_free, load_out;

  assign mc       = eff_cost_cap(cfg_i.cost_cap);
  assign out_free = ~out_valid_q | out_ready_i;
  assign pop_o    = (state_q == S_IDLE) & job_valid_i & out_free;
  assign load_out = (pop_o & (job_status_i != ST_SCORED)) | ((state_q == S_OUT) & out_free);

  assign num_mul = cfg_i.use_max ? NUM_W'(cfg_i.weight) * NUM_W'(job_largest_i)
                                 : NUM_W'(cfg_i.weight) * NUM_W'(job_sum_i);
  assign den_mul = cfg_i.use_max ? DEN_W'(mc) : DEN_W'(job_count_i) * DEN_W'(mc);

  // One quotient bit per cycle, restoring.
  assign rem_sh = {rem_q, quot_q[NUM_W-1]};
  assign diff   = rem_sh - {1'b0, den_q};
  assign ge     = (rem_sh >= {1'b0, den_q});

  assign out_valid_o  = out_valid_q;
  assign out_ok_o     = out_ok_q;
  assign out_status_o = out_status_q;
  assign out_cost_o   = out_cost_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      quot_q       <= '0;
      den_q        <= '0;
      rem_q        <= '0;
      it_q         <= '0;
      out_valid_q  <= 1'b0;
      out_ok_q     <= 1'b0;
      out_status_q <= ST_SCORED;
      out_cost_q   <= '0;
    end else begin
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (pop_o) begin
            if (job_status_i != ST_SCORED) begin
              out_ok_q     <= (job_status_i == ST_OFF_ACCEPT);
              out_status_q <= job_status_i;
              out_cost_q   <= '0;
            end else begin
              quot_q  <= num_mul;
              den_q   <= den_mul;
              rem_q   <= '0;
              it_q    <= '0;
              state_q <= S_DIV;
            end
          end
        end
        S_DIV: begin
          rem_q  <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
          quot_q <= {quot_q[NUM_W-2:0], ge};
          it_q   <= it_q + IT_W'(1);
          if (it_q == IT_W'(NUM_W - 1)) begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_ok_q     <= 1'b1;
            out_status_q <= ST_SCORED;
            // Guard a zero divisor: the cost is then zero.
            out_cost_q   <= (den_q == '0) ? '0 : quot_q[COST_W-1:0];
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/core/line_cost_reducer_unit.sv
// Path: a cell that does not end an edge is folded into the front-end accumulators; an ended edge
// is pushed into the queue and popped by the back end, which loads an unscored result into the
// output register once it is free and first runs a scored one through its bit-serial divider.
// Throughput: one cell per cycle; two ended edges queue while one divides, then the input stalls.
// Reset: rst_ni is asynchronous, active low; it clears the accumulators, queue and output register
// and loads the registers with their documented defaults. No clearing pass follows.
`include "assert_macros.svh"

module line_cost_reducer_unit #(
  parameter int unsigned MAX_SAMPLES = 4096
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  lcr_in_if.sink                          in_i,
  lcr_out_if.source                       out_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lcr_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [lcr_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [lcr_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import lcr_pkg::*;

  localparam int unsigned CNT_W   = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned SUM_W   = $clog2(MAX_SAMPLES * 255 + 1);
  localparam int unsigned JOB_W   = 3 + 8 + SUM_W + CNT_W;
  localparam int unsigned Q_DEPTH = 2;

  cfg_t             cfg;
  logic             push, pop, q_valid, q_full;
  status_e          f_status;
  logic [7:0]       f_largest;
  logic [SUM_W-1:0] f_sum;
  logic [CNT_W-1:0] f_count;
  logic [JOB_W-1:0] q_in, q_out;
  logic             out_unscored, out_ok_want;

  lcr_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  lcr_front #(.MAX_SAMPLES(MAX_SAMPLES)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .in_valid_i    (in_i.valid),
    .in_ready_o    (in_i.ready),
    .req_type_i    (in_i.req_type),
    .cell_cost_i   (in_i.cell_cost),
    .last_cell_i   (in_i.last_cell),
    .q_full_i      (q_full),
    .push_o        (push),
    .job_status_o  (f_status),
    .job_largest_o (f_largest),
    .job_sum_o     (f_sum),
    .job_count_o   (f_count)
  );

  assign q_in = {f_status, f_largest, f_sum, f_count};

  lcr_queue #(.DATA_W(JOB_W), .DEPTH(Q_DEPTH)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (q_in),
    .pop_i   (pop),
    .valid_o (q_valid),
    .full_o  (q_full),
    .data_o  (q_out)
  );

  lcr_back #(.MAX_SAMPLES(MAX_SAMPLES)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .job_valid_i   (q_valid),
    .job_status_i  (status_e'(q_out[JOB_W-1 -: 3])),
    .job_largest_i (q_out[SUM_W+CNT_W +: 8]),
    .job_sum_i     (q_out[CNT_W +: SUM_W]),
    .job_count_i   (q_out[CNT_W-1:0]),
    .pop_o         (pop),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .out_ok_o      (out_o.edge_ok),
    .out_status_o  (out_o.status),
    .out_cost_o    (out_o.edge_cost)
  );

  assign out_unscored = (out_o.status != ST_SCORED);
  assign out_ok_want  = (out_o.status == ST_SCORED) || (out_o.status == ST_OFF_ACCEPT);

  `LCR_ASSERT_NOW(a_no_push_when_full, push, !q_full)
  `LCR_ASSERT_NOW(a_cost_zero_unscored, out_o.valid && out_unscored, out_o.edge_cost == '0)
  `LCR_ASSERT_NOW(a_ok_matches_status, out_o.valid, out_o.edge_ok == out_ok_want)
  `LCR_ASSERT_NEXT(a_pop_fills_or_divides, pop && q_out[JOB_W-1 -: 3] != ST_SCORED, out_o.valid)

endmodule

FILE: verif/line_cost_checker.sv
module line_cost_checker #(
  parameter int unsigned MAX_SAMPLES = 4096
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  lcr_in_if                              cells_i,
  lcr_out_if                             edges_i,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic                           pready,
  input  logic [lcr_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [lcr_pkg::CFG_DATA_W-1:0] pwdata,
  output int unsigned                    fail_count_o,
  output int unsigned                    pending_o
);
  import lcr_pkg::*;

  typedef struct packed {
    logic              edge_ok;
    status_e           status;
    logic [COST_W-1:0] edge_cost;
  } edge_result_t;

  cfg_t         regs;
  logic [19:0]  cost_sum;
  logic [12:0]  sample_count;
  logic [7:0]   peak_cost;
  logic [7:0]   stride_pos;
  logic         collided;
  logic         overflowed;
  edge_result_t expected_edges[$];
  int unsigned  fails;

  function automatic void clear_edge();
    cost_sum     = '0;
    sample_count = '0;
    peak_cost    = '0;
    stride_pos   = '0;
    collided     = 1'b0;
    overflowed   = 1'b0;
  endfunction

  function automatic void expect_edge(logic ok, status_e st, logic [COST_W-1:0] cost);
    expected_edges.push_back('{edge_ok: ok, status: st, edge_cost: cost});
  endfunction

  function automatic void write_reg(reg_idx_e idx, logic [CFG_DATA_W-1:0] value);
    case (idx)
      REG_USE_MAX:     regs.use_max     = value[0];
      REG_REJECT_COLL: regs.reject_coll = value[0];
      REG_REJECT_OFF:  regs.reject_off  = value[0];
      REG_COST_CAP:    regs.cost_cap    = value[7:0];
      REG_STRIDE:      regs.stride      = value[7:0];
      REG_WEIGHT:      regs.weight      = value[WEIGHT_W-1:0];
      REG_MAP_READY:   regs.map_ready   = value[0];
      default: ;
    endcase
  endfunction

  // Fold one accepted item into the edge state; queue a result when the edge ends.
  function automatic void fold_cell(logic req, logic [7:0] cost, logic last);
    logic [7:0]  threshold;
    logic [7:0]  stride;
    logic [63:0] den;
    logic [63:0] quot;
    threshold = (regs.cost_cap == 8'd0) ? 8'd1 : regs.cost_cap;
    stride    = (regs.stride == 8'd0) ? 8'd1 : regs.stride;
    if (req) begin
      if (!regs.map_ready)
        expect_edge(1'b0, ST_NO_MAP, '0);
      else if (regs.reject_off)
        expect_edge(1'b0, ST_OFF_REJECT, '0);
      else
        expect_edge(1'b1, ST_OFF_ACCEPT, '0);
      clear_edge();
    end else begin
      if (stride_pos == 8'd0) begin
        if (cost >= threshold && threshold != COST_UNKNOWN && regs.reject_coll)
          collided = 1'b1;
        if (32'(sample_count) >= MAX_SAMPLES) begin
          overflowed = 1'b1;
        end else begin
          sample_count = sample_count + 13'd1;
          cost_sum     = cost_sum + 20'(cost);
          if (cost != COST_UNKNOWN && cost > peak_cost)
            peak_cost = cost;
        end
      end
      stride_pos = (9'(stride_pos) + 9'd1 >= 9'(stride)) ? 8'd0 : stride_pos + 8'd1;
      if (last) begin
        if (!regs.map_ready) begin
          expect_edge(1'b0, ST_NO_MAP, '0);
        end else if (collided) begin
          expect_edge(1'b0, ST_COLLISION, '0);
        end else if (overflowed) begin
          expect_edge(1'b0, ST_TOO_LONG, '0);
        end else begin
          if (regs.use_max) begin
            quot = (64'(regs.weight) * 64'(peak_cost)) / 64'(threshold);
          end else begin
            den  = 64'(sample_count) * 64'(threshold);
            quot = (den == 64'd0) ? 64'd0 : (64'(regs.weight) * 64'(cost_sum)) / den;
          end
          expect_edge(1'b1, ST_SCORED, quot[COST_W-1:0]);
        end
        clear_edge();
      end
    end
  endfunction

  function automatic void check_edge();
    edge_result_t want;
    if (expected_edges.size() == 0) begin
      $error("edge result with none expected: status %0d edge_cost %0d",
             edges_i.status, edges_i.edge_cost);
      fails++;
    end else begin
      want = expected_edges.pop_front();
      if (edges_i.edge_ok !== want.edge_ok) begin
        $error("edge_ok mismatch: expected %0d, actual %0d", want.edge_ok, edges_i.edge_ok);
        fails++;
      end
      if (edges_i.status !== want.status) begin
        $error("status mismatch: expected %0d, actual %0d", want.status, edges_i.status);
        fails++;
      end
      if (edges_i.edge_cost !== want.edge_cost) begin
        $error("edge_cost mismatch: expected %0d, actual %0d",
               want.edge_cost, edges_i.edge_cost);
        fails++;
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs = CFG_RESET;
      clear_edge();
      expected_edges.delete();
      fails = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (psel && penable && pwrite && pready)
        write_reg(reg_idx_e'(paddr[4:2]), pwdata);
      if (edges_i.valid && edges_i.ready)
        check_edge();
      if (cells_i.valid && cells_i.ready)
        fold_cell(cells_i.req_type, cells_i.cell_cost, cells_i.last_cell);
      fail_count_o <= fails;
      pending_o    <= expected_edges.size();
    end
  end

endmodule

FILE: verif/tb_line_cost_reducer_unit.sv
module tb_line_cost_reducer_unit;
  import lcr_pkg::*;

  localparam int unsigned MAX_SAMPLES   = 4096;
  localparam int unsigned CYCLE_LIMIT   = 800000;
  localparam int unsigned RANDOM_ITEMS  = 1320;
  localparam int unsigned SETTLE_CYCLES = 60;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned burst_left;
  int unsigned random_sent;
  int unsigned cycle_count;
  int unsigned stall_tick = 0;
  logic [1:0]  stall_mode = 2'd0;
  cfg_t        cur_cfg;

  lcr_in_if  in_ch ();
  lcr_out_if out_ch ();

  line_cost_reducer_unit #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  line_cost_checker #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cells_i     (in_ch),
    .edges_i     (out_ch),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Receiver stalls: switch pattern every so often, including stretches of no stalls.
  always @(posedge clk_i) begin
    stall_tick <= stall_tick + 1;
    if (stall_tick % 160 == 0)
      stall_mode <= 2'($urandom_range(0, 3));
    case (stall_mode)
      2'd0:    out_ch.ready <= 1'b1;
      2'd1:    out_ch.ready <= 1'($urandom_range(0, 1));
      2'd2:    out_ch.ready <= ($urandom_range(0, 4) == 0);
      default: out_ch.ready <= ((stall_tick % 7) < 3);
    endcase
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("line_cost_reducer_unit verification failed");
    $finish;
  end

  task automatic reg_write(reg_idx_e idx, logic [CFG_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
  endtask

  task automatic write_all(cfg_t c);
    reg_write(REG_USE_MAX,     32'(c.use_max));
    reg_write(REG_REJECT_COLL, 32'(c.reject_coll));
    reg_write(REG_REJECT_OFF,  32'(c.reject_off));
    reg_write(REG_COST_CAP,    32'(c.cost_cap));
    reg_write(REG_STRIDE,      32'(c.stride));
    reg_write(REG_WEIGHT,      32'(c.weight));
    reg_write(REG_MAP_READY,   32'(c.map_ready));
    psel    <= 1'b0;
    penable <= 1'b0;
    cur_cfg = c;
  endtask

  // Bursts of random length, mostly with random gaps between them.
  task automatic send_cell(logic req, logic [7:0] cost, logic last);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
    burst_left--;
    in_ch.valid     <= 1'b1;
    in_ch.req_type  <= req;
    in_ch.cell_cost <= cost;
    in_ch.last_cell <= last;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  // Hold the sender until every expected result is back, then let the unit settle.
  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [7:0] draw_cost();
    logic [7:0] mc;
    mc = cur_cfg.cost_cap;
    case ($urandom_range(0, 9))
      0:       return 8'd0;
      1:       return COST_UNKNOWN;
      2:       return mc;
      3:       return mc - 8'd1;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Mostly well-formed edges; some end off map, a few are bare off-map items.
  task automatic random_edge();
    int unsigned len;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(21, 80) : $urandom_range(1, 20);
    for (int unsigned i = 1; i < len; i++) begin
      send_cell(1'b0, draw_cost(), 1'b0);
      random_sent++;
    end
    if ($urandom_range(0, 9) == 0)
      send_cell(1'b1, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    else
      send_cell(1'b0, draw_cost(), 1'b1);
    random_sent++;
  endtask

  function automatic cfg_t random_cfg();
    cfg_t c;
    c.use_max     = 1'($urandom_range(0, 1));
    c.reject_coll = 1'($urandom_range(0, 1));
    c.reject_off  = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 6))
      0:       c.cost_cap = 8'd0;
      1:       c.cost_cap = 8'd1;
      2:       c.cost_cap = 8'd255;
      3:       c.cost_cap = 8'd254;
      default: c.cost_cap = 8'($urandom_range(2, 253));
    endcase
    case ($urandom_range(0, 6))
      0:       c.stride = 8'd0;
      1:       c.stride = 8'd255;
      2:       c.stride = 8'($urandom_range(5, 254));
      default: c.stride = 8'($urandom_range(1, 4));
    endcase
    case ($urandom_range(0, 5))
      0:       c.weight = 16'd0;
      1:       c.weight = 16'hFFFF;
      2:       c.weight = 16'd1;
      default: c.weight = 16'($urandom_range(0, 65535));
    endcase
    c.map_ready = ($urandom_range(0, 4) != 0);
    return c;
  endfunction

  initial begin
    cfg_t c;
    int unsigned phase;
    rst_ni          = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    in_ch.valid     = 1'b0;
    in_ch.req_type  = 1'b0;
    in_ch.cell_cost = '0;
    in_ch.last_cell = 1'b0;
    burst_left      = 0;
    random_sent     = 0;
    cur_cfg         = CFG_RESET;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: no map yet, so every edge ends without a map.
    send_cell(1'b0, 8'd10, 1'b0);
    send_cell(1'b0, COST_UNKNOWN, 1'b1);
    send_cell(1'b1, 8'hAA, 1'b1);
    settle();

    c = CFG_RESET;
    c.map_ready = 1'b1;
    write_all(c);
    // Stride two: the last cell falls off the stride and is skipped.
    send_cell(1'b0, 8'd0, 1'b0);
    send_cell(1'b0, 8'd252, 1'b0);
    send_cell(1'b0, 8'd200, 1'b0);
    send_cell(1'b0, 8'd254, 1'b1);
    // Collision on a sampled cell at the threshold.
    send_cell(1'b0, 8'd5, 1'b0);
    send_cell(1'b0, 8'd253, 1'b0);
    send_cell(1'b0, 8'd253, 1'b0);
    send_cell(1'b0, 8'd0, 1'b1);
    // Off map after some cells: drop what was gathered.
    send_cell(1'b0, 8'd100, 1'b0);
    send_cell(1'b1, 8'd0, 1'b0);
    // Unknown cost only: it meets the threshold, so the edge ends in a collision; largest stays zero.
    send_cell(1'b0, COST_UNKNOWN, 1'b1);
    settle();

    c = '{use_max: 1'b0, reject_coll: 1'b1, reject_off: 1'b0, cost_cap: 8'd0,
          stride: 8'd0, weight: 16'hFFFF, map_ready: 1'b1};
    write_all(c);
    send_cell(1'b1, 8'hFF, 1'b1);
    send_cell(1'b0, 8'd0, 1'b0);
    send_cell(1'b0, 8'd0, 1'b1);
    send_cell(1'b0, COST_UNKNOWN, 1'b1);
    settle();

    c = '{use_max: 1'b1, reject_coll: 1'b1, reject_off: 1'b1, cost_cap: 8'd255,
          stride: 8'd255, weight: 16'hFFFF, map_ready: 1'b1};
    write_all(c);
    send_cell(1'b0, 8'd254, 1'b0);
    send_cell(1'b0, COST_UNKNOWN, 1'b1);
    send_cell(1'b0, COST_UNKNOWN, 1'b1);
    settle();

    phase = 0;
    while (random_sent < RANDOM_ITEMS) begin
      write_all(random_cfg());
      for (int unsigned e = 0; e < 24 && random_sent < RANDOM_ITEMS; e++) begin
        random_edge();
        if (phase == 3 && e == 11)
          settle();
      end
      settle();
      phase++;
    end

    if (fail_count == 0 && pending == 0)
      $display("line_cost_reducer_unit verification clean");
    else
      $display("line_cost_reducer_unit verification failed");
    $finish;
  end

endmodule

FILE: line_cost_reducer_unit.f
+incdir+rtl/core
rtl/core/lcr_pkg.sv
rtl/core/lcr_if.sv
rtl/core/lcr_cfg_regs.sv
rtl/core/lcr_front.sv
rtl/core/lcr_queue.sv
rtl/core/lcr_back.sv
rtl/core/line_cost_reducer_unit.sv
verif/line_cost_checker.sv
verif/tb_line_cost_reducer_unit.sv
